// File: sv/rwsv_pkg.sv
package rwsv_pkg;

   // Fixed frame bytes
   localparam logic [7:0] FRAME_LEN_BYTE = 8'h05;
   localparam logic [7:0] CHAN_ID_FIRST  = 8'h01;
   localparam logic [7:0] CHAN_ID_SECOND = 8'h02;

   // Byte positions inside one frame
   localparam logic [2:0] BYTE_HEAD = 3'd0;
   localparam logic [2:0] BYTE_LEN  = 3'd1;
   localparam logic [2:0] BYTE_CHAN = 3'd2;
   localparam logic [2:0] BYTE_CODE = 3'd3;
   localparam logic [2:0] BYTE_SUM  = 3'd4;

   // Register map
   localparam int          CSR_IDX_W        = 4;
   localparam logic [3:0]  REG_FRAME_HEAD   = 4'd0;
   localparam logic [3:0]  REG_DEFAULT_CODE = 4'd1;

   // Request kinds
   localparam logic ACT_PUSH   = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   // Channel select
   localparam logic CH_FIRST  = 1'b0;
   localparam logic CH_SECOND = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_DRAIN,
      ST_PICK,
      ST_EMIT
   } state_type;

   // Control from the sequencer to the ring store
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic       ch;
      logic [7:0] code;
   } ring_req_type;

   // Control from the sequencer to the tally unit
   typedef struct packed {
      logic clear;
      logic acc;
      logic pick;
   } tally_ctl_type;

endpackage

// File: sv/recency_weighted_status_vote_unit.sv
// Keeps the last WINDOW_LEN status codes of two channels in one on-chip memory
// and, on a report request, sends two 5-byte frames (head, 0x05, channel id,
// winning code, byte-sum checksum), the tenth byte flagged by rsp_tlast. A push
// is written straight from idle. A report walks each channel in turn: a set-up
// step, one memory read per ring entry through the single read port, a drain
// step for the registered read, a winner scan over the codes, and five bytes
// that wait out any output stall. Ring contents read as zero until written; no
// clearing pass is needed after reset. Configuration writes are accepted every
// cycle.
module recency_weighted_status_vote_unit #(
   parameter int WINDOW_LEN = 10,
   parameter int NUM_CODES  = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] status_code
   input  logic [1:0]                      req_tuser,   // [0] action, [1] channel
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] frame_byte
   output logic                            rsp_tlast,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rwsv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_data
);
   import rwsv_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int WT_W   = $clog2(WINDOW_LEN + 1);

   state_type         state_ff, state_in;
   logic              ch_ff, ch_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] k_ff, k_in;
   logic [WT_W-1:0]   wt_ff;
   logic              acc_pend_ff;
   logic [2:0]        byte_ff, byte_in;
   logic [7:0]        frame_head_ff, default_code_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]        rsp_tdata_ff;
   logic              rsp_tlast_ff;

   ring_req_type      ring_req;
   tally_ctl_type     tally_ctl;
   logic [SLOT_W-1:0] wr_pos;
   logic [7:0]        rd_code;
   logic [7:0]        winner;
   logic              pick_last;
   logic              req_fire;
   logic              out_free;
   logic              load_out;
   logic [7:0]        chan_id;
   logic [7:0]        checksum;
   logic [7:0]        frame_byte;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_head_ff   <= '0;
         default_code_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_HEAD:   frame_head_ff   <= csr_data;
            REG_DEFAULT_CODE: default_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Ring store and tally unit
   rwsv_ring #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .req     (ring_req),
      .rd_slot (slot_ff),
      .wr_pos  (wr_pos),
      .rd_code (rd_code)
   );

   rwsv_tally #(
      .WINDOW_LEN (WINDOW_LEN),
      .NUM_CODES  (NUM_CODES)
   ) u_tally (
      .clock        (clock),
      .reset        (reset),
      .ctl          (tally_ctl),
      .code         (rd_code),
      .weight       (wt_ff),
      .default_code (default_code_ff),
      .pick_last    (pick_last),
      .winner       (winner)
   );

   // Frame byte selection
   assign chan_id  = (ch_ff == CH_SECOND) ? CHAN_ID_SECOND : CHAN_ID_FIRST;
   assign checksum = frame_head_ff + FRAME_LEN_BYTE + chan_id + winner;

   always_comb begin
      case (byte_ff)
         BYTE_HEAD: frame_byte = frame_head_ff;
         BYTE_LEN:  frame_byte = FRAME_LEN_BYTE;
         BYTE_CHAN: frame_byte = chan_id;
         BYTE_CODE: frame_byte = winner;
         default:   frame_byte = checksum;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Sequencer: next state and control
   always_comb begin
      state_in       = state_ff;
      ch_in          = ch_ff;
      slot_in        = slot_ff;
      k_in           = k_ff;
      byte_in        = byte_ff;
      load_out       = 1'b0;
      ring_req.wr_en = 1'b0;
      ring_req.rd_en = 1'b0;
      ring_req.ch    = ch_ff;
      ring_req.code  = req_tdata;
      tally_ctl.clear = 1'b0;
      tally_ctl.acc   = acc_pend_ff;
      tally_ctl.pick  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ring_req.ch = req_tuser[1];
            if (req_fire) begin
               if (req_tuser[0] == ACT_PUSH) begin
                  ring_req.wr_en = 1'b1;
               end else begin
                  ch_in    = CH_FIRST;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // newest entry sits just before the write slot
            slot_in = (wr_pos == '0) ? SLOT_W'(WINDOW_LEN - 1) : wr_pos - 1'b1;
            k_in    = '0;
            tally_ctl.clear = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            ring_req.rd_en = 1'b1;
            slot_in = (slot_ff == '0) ? SLOT_W'(WINDOW_LEN - 1) : slot_ff - 1'b1;
            k_in    = k_ff + 1'b1;
            if (k_ff == SLOT_W'(WINDOW_LEN - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            tally_ctl.pick = 1'b1;
            if (pick_last) begin
               byte_in  = BYTE_HEAD;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               byte_in  = byte_ff + 1'b1;
               if (byte_ff == BYTE_SUM) begin
                  if (ch_ff == CH_FIRST) begin
                     ch_in    = CH_SECOND;
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         acc_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         acc_pend_ff <= (state_ff == ST_READ);
      end
   end

   // Walk and frame counters
   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      slot_ff <= slot_in;
      k_ff    <= k_in;
      byte_ff <= byte_in;
      wt_ff   <= WT_W'(WINDOW_LEN) - WT_W'(k_ff);
   end

   // Output register
   assign rsp_tvalid_in = load_out ? 1'b1 : (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= frame_byte;
         rsp_tlast_ff <= (ch_ff == CH_SECOND) && (byte_ff == BYTE_SUM);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Ring walk stays inside the window
   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (k_ff < SLOT_W'(WINDOW_LEN - 1)) ||
                                (k_ff == SLOT_W'(WINDOW_LEN - 1)))
      else $error("ring walk index out of range");

   // Winner scan only follows a completed walk
   a_pick_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> ($past(state_ff) == ST_DRAIN) ||
                                ($past(state_ff) == ST_PICK))
      else $error("winner scan started without a finished walk");

   // No accumulation while frames are being sent
   a_no_acc_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !acc_pend_ff)
      else $error("tally changed during frame output");

   // Ring is never written during a report
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      ring_req.wr_en |-> (state_ff == ST_IDLE))
      else $error("ring written during a report");

endmodule

// File: sv/rwsv_ring.sv
module rwsv_ring #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rwsv_pkg::ring_req_type         req,
   input  logic [$clog2(WINDOW_LEN)-1:0]  rd_slot,
   output logic [$clog2(WINDOW_LEN)-1:0]  wr_pos,
   output logic [7:0]                     rd_code
);
   import rwsv_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int ADDR_W = SLOT_W + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   // Both rings share one memory, addressed {channel, slot}
   logic [7:0]        mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [SLOT_W-1:0] pos_ff [2];
   logic [SLOT_W-1:0] pos_in [2];
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [SLOT_W-1:0] pos_next;

   assign wr_pos  = pos_ff[req.ch];
   assign wr_addr = {req.ch, wr_pos};
   assign rd_addr = {req.ch, rd_slot};

   // Next write slot with wrap
   assign pos_next = (wr_pos == SLOT_W'(WINDOW_LEN - 1)) ? '0 : wr_pos + 1'b1;

   always_comb begin
      valid_in  = valid_ff;
      pos_in[0] = pos_ff[0];
      pos_in[1] = pos_ff[1];
      if (req.wr_en) begin
         valid_in[wr_addr] = 1'b1;
         pos_in[req.ch]    = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
      end else begin
         valid_ff  <= valid_in;
         pos_ff[0] <= pos_in[0];
         pos_ff[1] <= pos_in[1];
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[wr_addr] <= req.code;
      end
      if (req.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Never-written entries read as zero
   assign rd_code = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

// File: sv/rwsv_tally.sv
module rwsv_tally #(
   parameter int WINDOW_LEN = 10,
   parameter int NUM_CODES  = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rwsv_pkg::tally_ctl_type          ctl,
   input  logic [7:0]                       code,
   input  logic [$clog2(WINDOW_LEN+1)-1:0]  weight,
   input  logic [7:0]                       default_code,
   output logic                             pick_last,
   output logic [7:0]                       winner
);
   import rwsv_pkg::*;

   localparam int MAX_SUM = WINDOW_LEN * (WINDOW_LEN + 1) / 2;
   localparam int SUM_W   = $clog2(MAX_SUM + 1);
   localparam int CODE_W  = $clog2(NUM_CODES);

   logic [SUM_W-1:0]  sums_ff [NUM_CODES];
   logic [SUM_W-1:0]  best_ff;
   logic [7:0]        win_ff;
   logic [CODE_W-1:0] pick_cnt_ff;
   logic [SUM_W-1:0]  cand;

   // One accumulator per code, each adds only on its own code
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CODES; i++) begin
         if (ctl.clear) begin
            sums_ff[i] <= '0;
         end else if (ctl.acc && (code == 8'(i))) begin
            sums_ff[i] <= sums_ff[i] + SUM_W'(weight);
         end
      end
   end

   // Scan codes one per cycle, strict compare keeps the lowest on a tie
   assign cand      = sums_ff[pick_cnt_ff];
   assign pick_last = (pick_cnt_ff == CODE_W'(NUM_CODES - 1));

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         best_ff <= '0;
         win_ff  <= default_code;
      end else if (ctl.pick && (cand > best_ff)) begin
         best_ff <= cand;
         win_ff  <= 8'(pick_cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_cnt_ff <= '0;
      end else if (ctl.clear) begin
         pick_cnt_ff <= '0;
      end else if (ctl.pick && !pick_last) begin
         pick_cnt_ff <= pick_cnt_ff + 1'b1;
      end
   end

   assign winner = win_ff;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rwsv_pkg::*;

   localparam int WINDOW_LEN    = 10;
   localparam int NUM_CODES     = 5;
   // one report at the defaults, no output stall
   localparam int REPORT_CYCLES = 2 * (WINDOW_LEN + NUM_CODES + 7);
   localparam int SETTLE_CYCLES = 2 * REPORT_CYCLES;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_PCT      = 34;
   localparam logic [3:0] REG_UNUSED = 4'd15;

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   // one line of the directed table
   typedef struct {
      row_kind_type kind;
      logic       act;
      logic       ch;
      logic [7:0] code;      // status code, or register data for a CSR row
      int         rep;
      logic [3:0] idx;
      logic       has_exp;
      logic [7:0] exp_first;
      logic [7:0] exp_second;
   } dir_row_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] status_code
   logic [1:0] req_tuser = 2'b00;   // [0] action, [1] channel
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] frame_byte
   logic       rsp_tlast;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_data = 8'h00;

   // mirror of the block
   logic [7:0]  history_codes [2][WINDOW_LEN];
   int          next_slot [2];
   logic [7:0]  head_reg = 8'h00;
   logic [7:0]  dflt_reg = 8'h00;
   frame_byte_type pending_bytes [$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   int  hold_request = 0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;

   dir_row_type dir_tab [$];

   recency_weighted_status_vote_unit #(
      .WINDOW_LEN(WINDOW_LEN),
      .NUM_CODES (NUM_CODES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      if (error_count < 100)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // weighted vote over one ring: newest weighs WINDOW_LEN, oldest 1
   function automatic logic [7:0] ring_winner(input int ch);
      int unsigned sums [NUM_CODES];
      int unsigned best;
      logic [7:0]  winner;
      int          k;
      int          slot;
      logic [7:0]  c;
      best   = 0;
      winner = dflt_reg;
      for (k = 0; k < NUM_CODES; k++)
         sums[k] = 0;
      for (k = 0; k < WINDOW_LEN; k++) begin
         slot = (next_slot[ch] + WINDOW_LEN - 1 - k) % WINDOW_LEN;
         c    = history_codes[ch][slot];
         if (c < NUM_CODES)
            sums[c] += WINDOW_LEN - k;
      end
      // strict compare keeps the lowest code on a tie
      for (k = 0; k < NUM_CODES; k++) begin
         if (sums[k] > best) begin
            best   = sums[k];
            winner = k[7:0];
         end
      end
      return winner;
   endfunction

   task automatic queue_frame(input logic [7:0] chan_id, input logic [7:0] code,
                              input logic final_frame);
      logic [7:0] b [5];
      int         i;
      b[0] = head_reg;
      b[1] = FRAME_LEN_BYTE;
      b[2] = chan_id;
      b[3] = code;
      b[4] = b[0] + b[1] + b[2] + b[3];
      for (i = 0; i < 5; i++)
         pending_bytes.push_back('{value: b[i], last: final_frame && (i == 4)});
   endtask

   // update the mirror for one accepted request word
   task automatic apply_request(input logic act, input logic ch, input logic [7:0] code,
                                input logic has_exp, input logic [7:0] exp_first,
                                input logic [7:0] exp_second);
      int ci;
      ci = (ch == CH_SECOND) ? 1 : 0;
      if (act == ACT_PUSH) begin
         history_codes[ci][next_slot[ci]] = code;
         next_slot[ci] = (next_slot[ci] + 1) % WINDOW_LEN;
      end else begin
         queue_frame(CHAN_ID_FIRST,  has_exp ? exp_first  : ring_winner(0), 1'b0);
         queue_frame(CHAN_ID_SECOND, has_exp ? exp_second : ring_winner(1), 1'b1);
      end
   endtask

   task automatic send_request(input logic act, input logic ch, input logic [7:0] code,
                               input logic has_exp, input logic [7:0] exp_first,
                               input logic [7:0] exp_second);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {ch, act};
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      apply_request(act, ch, code, has_exp, exp_first, exp_second);
   endtask

   // block is idle once all bytes are back and a report's time has passed
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_FRAME_HEAD)
         head_reg = data;
      else if (idx == REG_DEFAULT_CODE)
         dflt_reg = data;
      @(posedge clock);
   endtask

   function automatic dir_row_type item_row(input logic act, input logic ch,
                                            input logic [7:0] code, input int rep);
      return '{kind: ROW_ITEM, act: act, ch: ch, code: code, rep: rep,
               idx: REG_FRAME_HEAD, has_exp: 1'b0, exp_first: 8'h00, exp_second: 8'h00};
   endfunction

   function automatic dir_row_type csr_row(input logic [3:0] idx, input logic [7:0] data);
      return '{kind: ROW_CSR, act: ACT_PUSH, ch: CH_FIRST, code: data, rep: 1,
               idx: idx, has_exp: 1'b0, exp_first: 8'h00, exp_second: 8'h00};
   endfunction

   function automatic dir_row_type report_row(input logic has_exp, input logic [7:0] exp_first,
                                              input logic [7:0] exp_second);
      return '{kind: ROW_ITEM, act: ACT_REPORT, ch: CH_FIRST, code: 8'h00, rep: 1,
               idx: REG_FRAME_HEAD, has_exp: has_exp, exp_first: exp_first,
               exp_second: exp_second};
   endfunction

   // output side: random stalls, long hold on request, byte checks
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bytes.size() == 0) begin
               report_error($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
            end else begin
               if (rsp_tdata !== pending_bytes[0].value)
                  report_error($sformatf("frame byte %02h, expected %02h",
                                         rsp_tdata, pending_bytes[0].value));
               if (rsp_tlast !== pending_bytes[0].last)
                  report_error($sformatf("last flag %0b, expected %0b",
                                         rsp_tlast, pending_bytes[0].last));
               void'(pending_bytes.pop_front());
            end
         end
         if (hold_request > 0 && !hold_taken) begin
            hold_left  = hold_request;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!idle_on) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int         r;
      int         bad_pct;
      int         i;
      int         p;
      int         n;
      logic       act;
      logic       ch;
      logic [7:0] code;

      for (i = 0; i < WINDOW_LEN; i++) begin
         history_codes[0][i] = 8'h00;
         history_codes[1][i] = 8'h00;
      end
      next_slot[0] = 0;
      next_slot[1] = 0;

      // directed table
      dir_tab.push_back(report_row(1'b1, 8'h00, 8'h00));     // rings of zeros after reset
      dir_tab.push_back(csr_row(REG_FRAME_HEAD, 8'hFF));
      dir_tab.push_back(csr_row(REG_DEFAULT_CODE, 8'hFF));
      dir_tab.push_back(csr_row(REG_UNUSED, 8'h5A));         // stray index, ignored
      dir_tab.push_back(report_row(1'b1, 8'h00, 8'h00));     // zeros still vote
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, 8'hFF, WINDOW_LEN + 1)); // wraps
      dir_tab.push_back(report_row(1'b1, 8'hFF, 8'h00));     // no valid vote on ring one
      dir_tab.push_back(item_row(ACT_PUSH, CH_SECOND, 8'd4, 1));
      dir_tab.push_back(report_row(1'b0, 8'h00, 8'h00));
      dir_tab.push_back(item_row(ACT_PUSH, CH_SECOND, 8'd4, 4));
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, NUM_CODES[7:0], 1)); // just out of range
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, 8'd4, 1));
      dir_tab.push_back(report_row(1'b0, 8'h00, 8'h00));
      // tie between codes 1 and 2, lowest wins
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, 8'd2, 2));
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, 8'd1, 1));
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, 8'hFF, 7));
      dir_tab.push_back(report_row(1'b0, 8'h00, 8'h00));
      dir_tab.push_back(csr_row(REG_FRAME_HEAD, 8'h00));
      dir_tab.push_back(csr_row(REG_DEFAULT_CODE, 8'h00));
      dir_tab.push_back(item_row(ACT_PUSH, CH_SECOND, 8'h00, 3));
      dir_tab.push_back(item_row(ACT_PUSH, CH_SECOND, 8'hAA, 1));
      dir_tab.push_back(item_row(ACT_PUSH, CH_FIRST, 8'h55, 1));
      dir_tab.push_back(report_row(1'b0, 8'h00, 8'h00));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[t]) begin
         if (dir_tab[t].kind == ROW_CSR) begin
            wait_idle();
            write_reg(dir_tab[t].idx, dir_tab[t].code);
         end else begin
            repeat (dir_tab[t].rep)
               send_request(dir_tab[t].act, dir_tab[t].ch, dir_tab[t].code,
                            dir_tab[t].has_exp, dir_tab[t].exp_first, dir_tab[t].exp_second);
         end
      end

      // random phases, each with its own register setting
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin
               write_reg(REG_FRAME_HEAD, 8'hFF);
               write_reg(REG_DEFAULT_CODE, 8'h00);
            end
            1: begin
               write_reg(REG_FRAME_HEAD, 8'h00);
               write_reg(REG_DEFAULT_CODE, 8'hFF);
            end
            default: begin
               write_reg(REG_FRAME_HEAD, 8'($urandom_range(0, 255)));
               write_reg(REG_DEFAULT_CODE, 8'($urandom_range(0, 255)));
            end
         endcase
         if ($urandom_range(0, 1))
            write_reg(4'($urandom_range(2, 15)), 8'($urandom_range(0, 255)));

         idle_on = (p != 4);
         if (p == 2)
            hold_request = HOLD_CYCLES;
         case ($urandom_range(0, 2))
            0:       bad_pct = 10;
            1:       bad_pct = 40;
            default: bad_pct = 85;
         endcase

         for (n = 0; n < PHASE_ITEMS; n++) begin
            r    = $urandom_range(0, 99);
            act  = (r < 28) ? ACT_REPORT : ACT_PUSH;
            ch   = 1'($urandom_range(0, 1));
            r    = $urandom_range(0, 99);
            if (r < bad_pct)
               code = (r & 1) ? 8'($urandom_range(NUM_CODES, 255))
                              : 8'($urandom_range(NUM_CODES, NUM_CODES + 2));
            else
               code = 8'($urandom_range(0, NUM_CODES - 1));
            send_request(act, ch, code, 1'b0, 8'h00, 8'h00);
         end
         idle_on = 1'b1;
      end
      req_tvalid <= 1'b0;

      // drain and settle
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0)
         report_error($sformatf("%0d bytes never arrived", pending_bytes.size()));

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
